// File: hdl/quc_pkg.sv
// Quota checker package: item, result, configuration and state types,
// notice codes and register indexes. No dependencies.
package quc_pkg;

	// Configuration register indexes
	localparam int unsigned CfgAddrW = 3;
	localparam logic [CfgAddrW-1:0] REG_QUOTAS_ENABLED   = 3'd0;
	localparam logic [CfgAddrW-1:0] REG_BLOCK_HARD_LIMIT = 3'd1;
	localparam logic [CfgAddrW-1:0] REG_BLOCK_SOFT_LIMIT = 3'd2;
	localparam logic [CfgAddrW-1:0] REG_FILE_HARD_LIMIT  = 3'd3;
	localparam logic [CfgAddrW-1:0] REG_FILE_SOFT_LIMIT  = 3'd4;
	localparam logic [CfgAddrW-1:0] REG_BLOCK_GRACE      = 3'd5;
	localparam logic [CfgAddrW-1:0] REG_FILE_GRACE       = 3'd6;

	// Notice codes
	localparam logic [2:0] NOTE_NONE       = 3'd0;
	localparam logic [2:0] NOTE_BLK_HARD   = 3'd1;
	localparam logic [2:0] NOTE_BLK_SOFT   = 3'd2;
	localparam logic [2:0] NOTE_BLK_TIME   = 3'd3;
	localparam logic [2:0] NOTE_BLK_OVFL   = 3'd4;
	localparam logic [2:0] NOTE_FILE_HARD  = 3'd5;
	localparam logic [2:0] NOTE_FILE_SOFT  = 3'd6;
	localparam logic [2:0] NOTE_FILE_TIME  = 3'd7;

	// Item action codes
	localparam logic ACT_BLOCK = 1'b0;
	localparam logic ACT_FILE  = 1'b1;

	localparam logic [31:0] MAX32 = 32'hffff_ffff;

	typedef struct packed {
		logic               action;
		logic signed [31:0] amount;
		logic               by_inode;
		logic               has_record;
		logic               force_req;
		logic               owner_is_root;
		logic               caller_is_owner;
		logic        [31:0] now_seconds;
	} in_item_t;

	typedef struct packed {
		logic        refused;
		logic [2:0]  notice;
		logic [31:0] block_count;
		logic [31:0] file_count;
		logic        dirty;
	} out_item_t;

	typedef struct packed {
		logic        quotas_enabled;
		logic [31:0] block_hard_limit;
		logic [31:0] block_soft_limit;
		logic [31:0] file_hard_limit;
		logic [31:0] file_soft_limit;
		logic [23:0] block_grace;
		logic [23:0] file_grace;
	} cfg_t;

	typedef struct packed {
		logic [31:0] block_usage;
		logic [32:0] block_deadline;
		logic [31:0] file_usage;
		logic [32:0] file_deadline;
		logic        block_warned;
		logic        file_warned;
		logic        modified;
	} quota_state_t;

endpackage

// File: hdl/quc_cfg.sv
// Quota checker configuration registers: write-only register file.
// Depends on quc_pkg.
module quc_cfg import quc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [31:0]         cfg_wdata,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_QUOTAS_ENABLED:   cfg_q.quotas_enabled   <= cfg_wdata[0];
				REG_BLOCK_HARD_LIMIT: cfg_q.block_hard_limit <= cfg_wdata;
				REG_BLOCK_SOFT_LIMIT: cfg_q.block_soft_limit <= cfg_wdata;
				REG_FILE_HARD_LIMIT:  cfg_q.file_hard_limit  <= cfg_wdata;
				REG_FILE_SOFT_LIMIT:  cfg_q.file_soft_limit  <= cfg_wdata;
				REG_BLOCK_GRACE:      cfg_q.block_grace      <= cfg_wdata[23:0];
				REG_FILE_GRACE:       cfg_q.file_grace       <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/quc_eval.sv
// Quota checker evaluation: next state and result for one item, combinational.
// Depends on quc_pkg.
module quc_eval import quc_pkg::*; (
	input  cfg_t         cfg,
	input  quota_state_t st,
	input  in_item_t     item,
	output quota_state_t st_nxt,
	output out_item_t    res
);

	logic [31:0] amt;
	logic [31:0] mag;
	logic [32:0] blk_sum;
	logic [32:0] blk_diff;
	logic [31:0] blk_rel;
	logic [32:0] now33;
	logic [32:0] blk_dl_new;
	logic [32:0] file_dl_new;
	logic        up;
	logic [31:0] fnc;
	logic [31:0] fdec;
	logic        refused;
	logic [2:0]  notice;
	logic        active;

	// Shared arithmetic
	assign amt         = item.amount;
	assign mag         = ~amt + 32'd1;
	assign blk_sum     = {1'b0, st.block_usage} + {1'b0, amt};
	assign blk_diff    = {1'b0, st.block_usage} - {1'b0, mag};
	assign blk_rel     = blk_diff[32] ? 32'd0 : blk_diff[31:0];
	assign now33       = {1'b0, item.now_seconds};
	assign blk_dl_new  = now33 + {9'd0, cfg.block_grace};
	assign file_dl_new = now33 + {9'd0, cfg.file_grace};
	assign up          = ~amt[31];
	assign fdec        = (st.file_usage == 32'd0) ? 32'd0 : st.file_usage - 32'd1;
	assign fnc         = up ? ((st.file_usage == MAX32) ? MAX32 : st.file_usage + 32'd1)
	                        : fdec;
	assign active      = cfg.quotas_enabled && (amt != 32'd0);

	// Item evaluation
	always_comb begin
		st_nxt  = st;
		refused = 1'b0;
		notice  = NOTE_NONE;
		if (active && item.action == ACT_BLOCK && item.has_record) begin
			if (amt[31]) begin
				// block release: floor at zero
				st_nxt.modified     = 1'b1;
				st_nxt.block_usage  = blk_rel;
				if (blk_rel < cfg.block_soft_limit)
					st_nxt.block_deadline = '0;
				st_nxt.block_warned = 1'b0;
			end else begin
				if (!item.owner_is_root) begin
					priority if (cfg.block_hard_limit != 32'd0 &&
					             blk_sum >= {1'b0, cfg.block_hard_limit} &&
					             !item.force_req) begin
						if (!st.block_warned && item.caller_is_owner) begin
							notice              = NOTE_BLK_HARD;
							st_nxt.block_warned = 1'b1;
						end
						refused = 1'b1;
					end else if (cfg.block_soft_limit != 32'd0 &&
					             blk_sum >= {1'b0, cfg.block_soft_limit}) begin
						if (st.block_usage < cfg.block_soft_limit ||
						    st.block_deadline == 33'd0) begin
							st_nxt.modified       = 1'b1;
							st_nxt.block_deadline = blk_dl_new;
							if (item.caller_is_owner)
								notice = NOTE_BLK_SOFT;
						end else if (now33 > st.block_deadline && !item.force_req) begin
							if (!st.block_warned && item.caller_is_owner) begin
								notice              = NOTE_BLK_TIME;
								st_nxt.block_warned = 1'b1;
							end
							refused = 1'b1;
						end
					end else begin
					end
				end
				if (!refused) begin
					st_nxt.modified = 1'b1;
					if (blk_sum[32]) begin
						st_nxt.block_usage = MAX32;
						notice             = NOTE_BLK_OVFL;
					end else begin
						st_nxt.block_usage = blk_sum[31:0];
					end
				end
			end
		end else if (active && item.action == ACT_FILE) begin
			if (!up && item.by_inode) begin
				// release of a named inode
				if (item.has_record) begin
					if (st.file_usage != 32'd0)
						st_nxt.modified = 1'b1;
					st_nxt.file_usage = fdec;
					if (fdec < cfg.file_soft_limit) begin
						st_nxt.file_deadline = '0;
						st_nxt.modified      = 1'b1;
					end
					st_nxt.file_warned = 1'b0;
				end
			end else if (cfg.file_soft_limit != 32'd0 || cfg.file_hard_limit != 32'd0) begin
				if (!item.owner_is_root && up) begin
					priority if (fnc >= cfg.file_hard_limit && cfg.file_hard_limit != 32'd0 &&
					             !item.force_req) begin
						if (!st.file_warned && item.caller_is_owner) begin
							notice             = NOTE_FILE_HARD;
							st_nxt.file_warned = 1'b1;
						end
						refused = 1'b1;
					end else if (fnc >= cfg.file_soft_limit &&
					             cfg.file_soft_limit != 32'd0) begin
						if (fnc == cfg.file_soft_limit || st.file_deadline == 33'd0) begin
							st_nxt.modified      = 1'b1;
							st_nxt.file_deadline = file_dl_new;
							if (item.caller_is_owner)
								notice = NOTE_FILE_SOFT;
						end else if (now33 > st.file_deadline && !item.force_req) begin
							if (!st.file_warned && item.caller_is_owner) begin
								notice             = NOTE_FILE_TIME;
								st_nxt.file_warned = 1'b1;
							end
							refused = 1'b1;
						end
					end else begin
					end
				end
				if (!refused) begin
					st_nxt.modified   = 1'b1;
					st_nxt.file_usage = fnc;
				end
			end
		end
	end

	// Result item
	always_comb begin
		res.refused     = refused;
		res.notice      = notice;
		res.block_count = st_nxt.block_usage;
		res.file_count  = st_nxt.file_usage;
		res.dirty       = st_nxt.modified;
	end

endmodule

// File: hdl/quota_usage_limit_checker.sv
// Quota usage limit checker top level: input register, evaluation, state and
// result register. Depends on quc_pkg, quc_cfg and quc_eval.
//
// Usage:
//   Items enter on in_valid/in_ready with an in_item_t payload; results leave
//   on out_valid/out_ready as out_item_t, exactly one result per item, in order.
//   Configuration is written through cfg_we/cfg_addr/cfg_wdata, one register
//   per cycle; the user must write it only while no item is in flight, as the
//   block itself does not enforce this. An accepted item passes the input
//   register, then the result register. Throughput: one item per cycle while
//   the output is not stalled; the owner's usage, deadlines and flags are
//   updated as the result is registered, so the following item sees them at once.
//   Reset: clears configuration (quotas disabled, all limits zero), usage,
//   deadlines, warned flags and the dirty flag; both stages come up empty.
//   Stall: while out_ready is low the result is held; one more item can be
//   taken into the input register, after which in_ready drops until the
//   result is taken.
module quota_usage_limit_checker import quc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_item,
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [31:0]         cfg_wdata
);

	cfg_t         cfg;
	quota_state_t st_q;
	quota_state_t st_nxt;
	in_item_t     item_s1;
	logic         valid_s1;
	out_item_t    res_nxt;
	out_item_t    res_s2;
	logic         valid_s2;
	logic         adv;

	quc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	quc_eval u_eval (
		.cfg    (cfg),
		.st     (st_q),
		.item   (item_s1),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	// Pipeline flow control
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	// Input item register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_item;
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_nxt;
	end

	// Owner quota state, committed with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

endmodule
